// ===== rtl/core/rau_pkg.sv =====
package rau_pkg;

  localparam int unsigned NumWidth = 32;
  localparam int unsigned MagW = 64;

  localparam logic [1:0] FuncAdd = 2'd0;
  localparam logic [1:0] FuncSub = 2'd1;
  localparam logic [1:0] FuncMul = 2'd2;
  localparam logic [1:0] FuncDiv = 2'd3;

  localparam logic [1:0] StatusOk   = 2'd0;
  localparam logic [1:0] StatusDivZ = 2'd1;
  localparam logic [1:0] StatusOvf  = 2'd2;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctrl_t;

endpackage

// ===== rtl/core/rau_div.sv =====
module rau_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [rau_pkg::MagW-1:0]        dividend_i,
  input  logic [rau_pkg::MagW-1:0]        divisor_i,
  output logic                            done_o,
  output logic [rau_pkg::MagW-1:0]        quot_o,
  output logic [rau_pkg::MagW-1:0]        rem_o
);

  logic [rau_pkg::MagW-1:0] q_q, q_d, r_q, r_d, d_q, d_d;
  logic [6:0]               cnt_q, cnt_d;
  logic                     busy_q, busy_d, done_q, done_d;
  logic [rau_pkg::MagW:0]   shl, diff;

  always_comb begin
    shl  = {r_q, q_q[rau_pkg::MagW-1]};
    diff = shl - {1'b0, d_q};
    q_d = q_q; r_d = r_q; d_d = d_q; cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      q_d = dividend_i; r_d = '0; d_d = divisor_i; cnt_d = 7'd0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[rau_pkg::MagW]) begin
        r_d = diff[rau_pkg::MagW-1:0];
        q_d = {q_q[rau_pkg::MagW-2:0], 1'b1};
      end else begin
        r_d = shl[rau_pkg::MagW-1:0];
        q_d = {q_q[rau_pkg::MagW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'(rau_pkg::MagW - 1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; d_q <= d_d;
  end

  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = r_q;

endmodule

// ===== rtl/core/rational_arithmetic_unit_top.sv =====
// channel | valid       | stall       | payload
// in      | in_valid_i  | in_stall_o  | func_i a_num_i a_den_i b_num_i b_den_i
// out     | out_valid_o | out_stall_i | res_num_o res_den_o status_o
// A zero denominator or a divide by zero goes straight to the output. Otherwise
// three products in StMul1 and StMul2, then Euclid's gcd on a shared 64-step
// restoring divider (up to 90 remainders), then two more divisions by the gcd;
// a new item is taken only once the last has left the output.
// Reset clears the sequencer; stall on out holds the result and blocks input.
module rational_arithmetic_unit_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic signed [31:0] a_num_i,
  input  logic [30:0] a_den_i,
  input  logic signed [31:0] b_num_i,
  input  logic [30:0] b_den_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] res_num_o,
  output logic [30:0] res_den_o,
  output logic [1:0]  status_o
);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StMul1 = 4'd1;
  localparam logic [3:0] StMul2 = 4'd2;
  localparam logic [3:0] StComb = 4'd3;
  localparam logic [3:0] StGcd  = 4'd4;
  localparam logic [3:0] StGw   = 4'd5;
  localparam logic [3:0] StDn   = 4'd6;
  localparam logic [3:0] StDnW  = 4'd7;
  localparam logic [3:0] StDd   = 4'd8;
  localparam logic [3:0] StDdW  = 4'd9;
  localparam logic [3:0] StChk  = 4'd10;
  localparam logic [3:0] StOut  = 4'd11;

  localparam logic [63:0] Lim = 64'd1 << (rau_pkg::NumWidth - 1);

  logic [3:0] st_q, st_d;
  logic [1:0] func_q;
  logic signed [31:0] an_q, bn_q;
  logic [30:0] ad_q, bd_q;
  logic signed [63:0] p1_q, p2_q, pd_q;
  logic [63:0] nm_q, dm_q, x_q, y_q;
  logic        neg_q;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic signed [63:0] n_c, d_c;
  logic signed [31:0] rn_q;
  logic [30:0] rd_q;
  logic [1:0]  stat_q;

  rau_pkg::div_ctrl_t dctl;
  logic [63:0] dv_a, dv_b, quot, rem;

  always_comb begin
    mul_a = an_q; mul_b = $signed({1'b0, bd_q});
    if (st_q == StMul1) begin
      if (func_q == rau_pkg::FuncMul) begin
        mul_a = an_q; mul_b = bn_q;
      end else begin
        mul_a = an_q; mul_b = $signed({1'b0, bd_q});
      end
    end else if (st_q == StMul2) begin
      if (func_q == rau_pkg::FuncDiv) begin
        mul_a = bn_q; mul_b = $signed({1'b0, ad_q});
      end else if (func_q == rau_pkg::FuncMul) begin
        mul_a = $signed({1'b0, ad_q}); mul_b = $signed({1'b0, bd_q});
      end else begin
        mul_a = bn_q; mul_b = $signed({1'b0, ad_q});
      end
    end else begin
      mul_a = $signed({1'b0, ad_q}); mul_b = $signed({1'b0, bd_q});
    end
  end
  assign mul_p = mul_a * mul_b;

  always_comb begin
    n_c = p1_q; d_c = pd_q;
    case (func_q)
      rau_pkg::FuncAdd: begin n_c = p1_q + p2_q; d_c = pd_q; end
      rau_pkg::FuncSub: begin n_c = p1_q - p2_q; d_c = pd_q; end
      rau_pkg::FuncMul: begin n_c = p1_q; d_c = p2_q; end
      default: begin
        if (bn_q < 0) begin n_c = -p1_q; d_c = -p2_q; end
        else begin n_c = p1_q; d_c = p2_q; end
      end
    endcase
  end

  assign dctl.start = (st_q == StGcd && y_q != 64'd0) || st_q == StDn || st_q == StDd;
  always_comb begin
    dv_a = x_q; dv_b = y_q;
    if (st_q == StDn) begin dv_a = nm_q; dv_b = x_q; end
    else if (st_q == StDd) begin dv_a = dm_q; dv_b = x_q; end
  end

  rau_div u_div (
    .clk_i, .rst_ni, .start_i(dctl.start), .dividend_i(dv_a), .divisor_i(dv_b),
    .done_o(dctl.done), .quot_o(quot), .rem_o(rem)
  );

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (in_valid_i) begin
        if (a_den_i == '0 || b_den_i == '0 ||
            (func_i == rau_pkg::FuncDiv && b_num_i == 32'sd0)) st_d = StOut;
        else st_d = StMul1;
      end
      StMul1: st_d = StMul2;
      StMul2: st_d = StComb;
      StComb: st_d = StGcd;
      StGcd:  st_d = (y_q == 64'd0) ? StDn : StGw;
      StGw:   if (dctl.done) st_d = StGcd;
      StDn:   st_d = StDnW;
      StDnW:  if (dctl.done) st_d = StDd;
      StDd:   st_d = StDdW;
      StDdW:  if (dctl.done) st_d = StChk;
      StChk:  st_d = StOut;
      StOut:  if (!out_stall_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: if (in_valid_i) begin
        func_q <= func_i; an_q <= a_num_i; ad_q <= a_den_i;
        bn_q <= b_num_i; bd_q <= b_den_i;
        rn_q <= '0; rd_q <= '0; stat_q <= rau_pkg::StatusDivZ;
      end
      StMul1: p1_q <= mul_p;
      StMul2: begin
        p2_q <= mul_p;
        pd_q <= $signed({1'b0, ad_q}) * $signed({1'b0, bd_q});
      end
      StComb: begin
        neg_q <= n_c < 0;
        nm_q  <= n_c < 0 ? 64'(-n_c) : 64'(n_c);
        dm_q  <= 64'(d_c);
        x_q   <= n_c < 0 ? 64'(-n_c) : 64'(n_c);
        y_q   <= 64'(d_c);
      end
      StGw: if (dctl.done) begin x_q <= y_q; y_q <= rem; end
      StDnW: if (dctl.done) nm_q <= quot;
      StDdW: if (dctl.done) dm_q <= quot;
      StChk: begin
        if (nm_q == 64'd0) begin
          rn_q <= '0; rd_q <= 31'd1; stat_q <= rau_pkg::StatusOk;
        end else if (dm_q > Lim - 64'd1 || (neg_q ? nm_q > Lim : nm_q > Lim - 64'd1)) begin
          rn_q <= '0; rd_q <= '0; stat_q <= rau_pkg::StatusOvf;
        end else begin
          rn_q <= neg_q ? -$signed(nm_q[31:0]) : $signed(nm_q[31:0]);
          rd_q <= dm_q[30:0]; stat_q <= rau_pkg::StatusOk;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o  = st_q != StIdle;
  assign out_valid_o = st_q == StOut;
  assign res_num_o   = rn_q;
  assign res_den_o   = rd_q;
  assign status_o    = stat_q;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam longint unsigned CycleLimit = 64'd100_000_000;
  localparam int NumRandom = 1150;
  localparam int TailCycles = 12000;

  typedef struct {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic [1:0]         st;
  } frac_t;

  class frac_scoreboard;
    frac_t pending[$];
    int errors = 0;

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function frac_t reduce_frac(logic [1:0] fn, logic signed [31:0] a_num, logic [30:0] a_den,
                                logic signed [31:0] b_num, logic [30:0] b_den);
      frac_t r;
      longint an, ad, bn, bd, n, d;
      longint unsigned nm, dm, x, y, t, lim;
      bit neg;
      r.num = '0;
      r.den = '0;
      r.st = rau_pkg::StatusDivZ;
      an = longint'(a_num);
      bn = longint'(b_num);
      ad = longint'(a_den);
      bd = longint'(b_den);
      if (ad == 0 || bd == 0) return r;
      d = ad * bd;
      case (fn)
        rau_pkg::FuncAdd: n = an * bd + bn * ad;
        rau_pkg::FuncSub: n = an * bd - bn * ad;
        rau_pkg::FuncMul: n = an * bn;
        default: begin
          if (bn == 0) return r;
          if (bn < 0) begin
            n = -(an * bd);
            d = -bn * ad;
          end else begin
            n = an * bd;
            d = bn * ad;
          end
        end
      endcase
      neg = n < 0;
      nm = neg ? longint'(-n) : longint'(n);
      dm = d;
      x = nm;
      y = dm;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      nm = nm / x;
      dm = dm / x;
      if (nm == 0) begin
        neg = 0;
        dm = 1;
      end
      lim = 64'd1 << (rau_pkg::NumWidth - 1);
      if (dm > lim - 1 || (neg ? nm > lim : nm > lim - 1)) begin
        r.st = rau_pkg::StatusOvf;
        return r;
      end
      r.num = neg ? 32'(-nm) : 32'(nm);
      r.den = 31'(dm);
      r.st = rau_pkg::StatusOk;
      return r;
    endfunction

    function void note_input(logic [1:0] fn, logic signed [31:0] an, logic [30:0] ad,
                             logic signed [31:0] bn, logic [30:0] bd);
      pending.push_back(reduce_frac(fn, an, ad, bn, bd));
    endfunction

    task check_result(logic signed [31:0] num, logic [30:0] den, logic [1:0] st);
      frac_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected item %0d/%0d st %0d", num, den, st));
      end else begin
        e = pending.pop_front();
        if (st !== e.st) report($sformatf("status %0d, want %0d", st, e.st));
        if (num !== e.num) report($sformatf("num %0d, want %0d", num, e.num));
        if (den !== e.den) report($sformatf("den %0d, want %0d", den, e.den));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] func_i = '0;
  logic signed [31:0] a_num_i = '0;
  logic [30:0] a_den_i = 31'd1;
  logic signed [31:0] b_num_i = '0;
  logic [30:0] b_den_i = 31'd1;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] res_num_o;
  logic [30:0] res_den_o;
  logic [1:0] status_o;

  frac_scoreboard sb = new();
  longint unsigned cycles = 0;
  int accepted = 0;
  bit hold_done = 0;
  int hold_left = 0;
  int stall_run = 0;

  rational_arithmetic_unit_top dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sb.note_input(func_i, a_num_i, a_den_i, b_num_i, b_den_i);
      accepted <= accepted + 1;
    end
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(res_num_o, res_den_o, status_o);
  end

  // receiver: random stall runs, plus one long hold-off after 20 accepted items while the sender keeps offering
  always @(posedge clk_i) begin
    if (!hold_done && accepted == 20) begin
      hold_done <= 1;
      hold_left <= 30000;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(50, 3000) : $urandom_range(0, 4);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 14) == 0) return $urandom_range(50, 4000);
    return $urandom_range(1, 5);
  endfunction

  function automatic logic signed [31:0] rand_num();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom_range(0, 2) - 1;
      3, 4, 5, 6: return $urandom_range(0, 2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_den();
    case ($urandom_range(0, 49))
      0: return 31'd0;
      1, 2, 3: return 31'h7fffffff;
      4, 5, 6, 7: return 31'd1;
      8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19, 20, 21, 22, 23, 24, 25:
        return $urandom_range(1, 1000);
      default: return 31'($urandom);
    endcase
  endfunction

  task send_frac(logic [1:0] fn, logic signed [31:0] an, logic [30:0] ad,
                 logic signed [31:0] bn, logic [30:0] bd);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    func_i <= fn;
    a_num_i <= an;
    a_den_i <= ad;
    b_num_i <= bn;
    b_den_i <= bd;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  initial begin
    int wait_cycles;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_frac(rau_pkg::FuncAdd, 32'sh7fffffff, 31'd1, 32'sh7fffffff, 31'd1);
    send_frac(rau_pkg::FuncAdd, 32'sd1, 31'd2, 32'sd1, 31'd3);
    send_frac(rau_pkg::FuncSub, 32'sd3, 31'd4, 32'sd3, 31'd4);
    send_frac(rau_pkg::FuncSub, 32'sh80000000, 31'd1, 32'sd1, 31'd1);
    send_frac(rau_pkg::FuncSub, 32'sh80000000, 31'd1, 32'sd0, 31'd1);
    send_frac(rau_pkg::FuncMul, 32'sh80000000, 31'd1, -32'sd1, 31'd1);
    send_frac(rau_pkg::FuncMul, 32'sh80000000, 31'd1, 32'sd1, 31'd1);
    send_frac(rau_pkg::FuncMul, 32'sd0, 31'd5, 32'sd3, 31'd7);
    send_frac(rau_pkg::FuncMul, 32'sd1, 31'h7fffffff, 32'sd1, 31'h7fffffff);
    send_frac(rau_pkg::FuncMul, 32'sh7fffffff, 31'h7fffffff, 32'sh80000000, 31'h7fffffff);
    send_frac(rau_pkg::FuncDiv, 32'sd5, 31'd3, 32'sd0, 31'd9);
    send_frac(rau_pkg::FuncDiv, 32'sh80000000, 31'd1, -32'sd1, 31'd1);
    send_frac(rau_pkg::FuncDiv, 32'sd2, 31'd3, -32'sd4, 31'd5);
    send_frac(rau_pkg::FuncDiv, 32'sh80000000, 31'h7fffffff, 32'sh80000000, 31'h7fffffff);
    send_frac(rau_pkg::FuncDiv, 32'sd0, 31'd1, 32'sd7, 31'd1);
    send_frac(rau_pkg::FuncAdd, 32'sd1, 31'd0, 32'sd1, 31'd1);
    send_frac(rau_pkg::FuncMul, 32'sd1, 31'd1, 32'sd1, 31'd0);
    send_frac(rau_pkg::FuncDiv, 32'sd0, 31'd0, 32'sd0, 31'd0);
    send_frac(rau_pkg::FuncSub, -32'sd1, 31'h7fffffff, 32'sh7fffffff, 31'd1);
    send_frac(rau_pkg::FuncAdd, 32'sh7fffffff, 31'h7ffffffe, 32'sh7ffffffe, 31'h7fffffff);

    repeat (NumRandom) send_frac(2'($urandom), rand_num(), rand_den(), rand_num(), rand_den());
    in_valid_i <= 1'b0;

    wait_cycles = 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    while (wait_cycles < TailCycles) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== rational_arithmetic_unit_top.f =====
rtl/core/rau_pkg.sv
rtl/core/rau_div.sv
rtl/core/rational_arithmetic_unit_top.sv
tb/sv/testbench.sv
